[rtl/sonar_echo_median_ranger_defines.svh]
// Assertion macros for the sonar echo median ranger.
`ifndef SONAR_ECHO_MEDIAN_RANGER_DEFINES_SVH
`define SONAR_ECHO_MEDIAN_RANGER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define SEMR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define SEMR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define SEMR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define SEMR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/semr_pkg.sv]
// Shared types and constants for the sonar echo median ranger.
package semr_pkg;

   localparam int SAMPLE_COUNT = 3;
   localparam int SLOT_W       = 2;
   localparam int CFG_W        = 10;
   localparam int DIST_W       = 11;
   localparam int LIMIT_W      = 16;
   localparam int US_PER_CM    = 58;

   localparam logic [CFG_W-1:0]  MAX_RANGE_RESET = 10'd600;
   localparam logic [DIST_W-1:0] DIST_OUT_RANGE  = 11'h7FF;

   // floor(m / 58) = ((m >> 1) * RECIP) >> RECIP_SHIFT, exact for m < 1024 * 58
   localparam logic [15:0] RECIP       = 16'd36158;
   localparam int          RECIP_SHIFT = 20;

   localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_LAST  = 2'(SAMPLE_COUNT - 1);

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/sonar_echo_median_ranger.sv]
// Top level of the sonar echo median ranger.
// Each request is one echo-pin edge (level and microsecond timestamp) and yields one
// response: the median of the last three valid pulse widths divided by 58, in
// centimeters, or -1 when that exceeds csr_wr_data as last written (reset 600).
// A rising edge latches the pulse start; a falling edge stores a width only if its
// time is later than the start. One request is taken per cycle unless req_stall is
// high (queue full); a response passes the queue write at acceptance, the median
// stage and the divide-and-range output register, in that order. A two-entry queue
// between front and back lets requests keep going while a response is stalled.
`include "sonar_echo_median_ranger_defines.svh"

module sonar_echo_median_ranger #(
   parameter int TIME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_echo_level,
   input  logic [31:0]                         req_timestamp_us,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [semr_pkg::DIST_W-1:0]  rsp_distance_cm,
   input  logic                                csr_wr_en,
   input  logic [semr_pkg::CFG_W-1:0]          csr_wr_data
);

   logic [semr_pkg::CFG_W-1:0]                        max_range_ff, max_range_in;
   semr_pkg::queue_status_type                        q_status;
   logic                                              push, pop;
   logic [semr_pkg::SAMPLE_COUNT-1:0][TIME_BITS-1:0]  push_samples, head_samples;
   logic [semr_pkg::DIST_W-1:0]                       dist_cm;

   assign max_range_in = csr_wr_en ? csr_wr_data : max_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= semr_pkg::MAX_RANGE_RESET;
      end else begin
         max_range_ff <= max_range_in;
      end
   end

   semr_front #(.TIME_BITS(TIME_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_echo_level   (req_echo_level),
      .req_timestamp_us (req_timestamp_us),
      .q_status         (q_status),
      .push             (push),
      .push_samples     (push_samples)
   );

   semr_queue #(.TIME_BITS(TIME_BITS)) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_samples (push_samples),
      .pop          (pop),
      .head_samples (head_samples),
      .status       (q_status)
   );

   semr_back #(.TIME_BITS(TIME_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head_samples    (head_samples),
      .pop             (pop),
      .max_range       (max_range_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_distance_cm (dist_cm)
   );

   assign rsp_distance_cm = dist_cm;

   `SEMR_ASSERT_NEXT(a_accept_fills_queue, clock, reset, req_valid && !req_stall, !q_status.empty)
   `SEMR_ASSERT_IMPLIES(a_dist_code, clock, reset, rsp_valid, !dist_cm[10] || dist_cm == semr_pkg::DIST_OUT_RANGE)
   `SEMR_ASSERT_IMPLIES(a_dist_in_limit, clock, reset, rsp_valid && !dist_cm[10], dist_cm[9:0] <= max_range_ff)

endmodule

[rtl/semr_front.sv]
// Front end: accepts echo edges, tracks pulse start and the width ring.
module semr_front #(
   parameter int TIME_BITS = 32
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  req_valid,
   output logic                                                  req_stall,
   input  logic                                                  req_echo_level,
   input  logic [31:0]                                           req_timestamp_us,
   input  semr_pkg::queue_status_type                            q_status,
   output logic                                                  push,
   output logic [semr_pkg::SAMPLE_COUNT-1:0][TIME_BITS-1:0]      push_samples
);

   logic [TIME_BITS-1:0]                                  start_ff, start_in;
   logic [semr_pkg::SAMPLE_COUNT-1:0][TIME_BITS-1:0]      samples_ff, samples_in;
   logic [semr_pkg::SLOT_W-1:0]                           slot_ff, slot_in;
   logic [TIME_BITS-1:0]                                  now;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;
   assign now       = req_timestamp_us[TIME_BITS-1:0];

   always_comb begin
      start_in   = start_ff;
      samples_in = samples_ff;
      slot_in    = slot_ff;
      if (push) begin
         if (req_echo_level) begin
            start_in = now;
         end else if (now > start_ff) begin
            samples_in[slot_ff] = now - start_ff;
            slot_in = (slot_ff == semr_pkg::SLOT_LAST) ? semr_pkg::SLOT_FIRST
                                                       : slot_ff + 2'd1;
         end
      end
   end

   // carry the ring as it stands after this request
   assign push_samples = samples_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         samples_ff <= '0;
         slot_ff    <= semr_pkg::SLOT_FIRST;
      end else begin
         start_ff   <= start_in;
         samples_ff <= samples_in;
         slot_ff    <= slot_in;
      end
   end

endmodule

[rtl/semr_queue.sv]
// Two-entry queue of sample snapshots between front and back.
module semr_queue #(
   parameter int TIME_BITS = 32
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  push,
   input  logic [semr_pkg::SAMPLE_COUNT-1:0][TIME_BITS-1:0]      push_samples,
   input  logic                                                  pop,
   output logic [semr_pkg::SAMPLE_COUNT-1:0][TIME_BITS-1:0]      head_samples,
   output semr_pkg::queue_status_type                            status
);

   logic [semr_pkg::SAMPLE_COUNT-1:0][TIME_BITS-1:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_pop       = pop && !status.empty;
   assign head_samples = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_samples;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/semr_back.sv]
// Back end: median of three, range check and divide by 58, output register.
module semr_back #(
   parameter int TIME_BITS = 32
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  semr_pkg::queue_status_type                            q_status,
   input  logic [semr_pkg::SAMPLE_COUNT-1:0][TIME_BITS-1:0]      head_samples,
   output logic                                                  pop,
   input  logic [semr_pkg::CFG_W-1:0]                            max_range,
   output logic                                                  rsp_valid,
   input  logic                                                  rsp_stall,
   output logic [semr_pkg::DIST_W-1:0]                           rsp_distance_cm
);

   logic                          med_vld_ff, med_vld_in;
   logic [TIME_BITS-1:0]          med_ff, med_in;
   logic                          out_vld_ff, out_vld_in;
   logic [semr_pkg::DIST_W-1:0]   dist_ff, dist_in;
   logic                          out_adv, med_adv;
   logic [TIME_BITS-1:0]          lo, hi, mid;
   logic [semr_pkg::LIMIT_W-1:0]  limit;
   logic [14:0]                   half;
   logic [30:0]                   prod;
   logic                          in_range;

   assign out_adv = !out_vld_ff || !rsp_stall;
   assign med_adv = !med_vld_ff || out_adv;
   assign pop     = med_adv && !q_status.empty;

   // median: sort first pair, clamp upper by third, take larger of the two
   always_comb begin
      if (head_samples[0] > head_samples[1]) begin
         lo = head_samples[1];
         hi = head_samples[0];
      end else begin
         lo = head_samples[0];
         hi = head_samples[1];
      end
      mid    = (hi > head_samples[2]) ? head_samples[2] : hi;
      med_in = (lo > mid) ? lo : mid;
   end

   // distance exceeds max exactly when median reaches (max + 1) * 58
   assign limit    = (semr_pkg::LIMIT_W'(max_range) + 16'd1)
                     * semr_pkg::LIMIT_W'(semr_pkg::US_PER_CM);
   assign in_range = med_ff < TIME_BITS'(limit);
   assign half     = med_ff[15:1];
   assign prod     = 31'(half) * 31'(semr_pkg::RECIP);

   always_comb begin
      if (in_range) begin
         dist_in = {1'b0, prod[semr_pkg::RECIP_SHIFT +: semr_pkg::CFG_W]};
      end else begin
         dist_in = semr_pkg::DIST_OUT_RANGE;
      end
   end

   assign med_vld_in = med_adv ? pop : med_vld_ff;
   assign out_vld_in = out_adv ? med_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         med_ff <= med_in;
      end
      if (out_adv && med_vld_ff) begin
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         med_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         med_vld_ff <= med_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_distance_cm = dist_ff;

endmodule

[verif/tb_sonar_echo_median_ranger.sv]
// Testbench for the sonar echo median ranger: directed and random echo edges, scoreboard check.
`timescale 1ns / 1ps

module tb_sonar_echo_median_ranger;
   localparam int DIST_W = semr_pkg::DIST_W;
   localparam int CFG_W  = semr_pkg::CFG_W;

   localparam int unsigned     US_PER_CM_CHK  = 58;
   localparam logic [CFG_W-1:0] RANGE_AT_RESET = 10'd600;
   localparam logic [CFG_W-1:0] RANGE_NONE     = 10'd0;
   localparam logic [CFG_W-1:0] RANGE_FULL     = 10'd1023;
   localparam logic [DIST_W-1:0] DIST_INVALID  = 11'h7FF;
   localparam logic             LEVEL_RISE     = 1'b1;
   localparam logic             LEVEL_FALL     = 1'b0;
   localparam int unsigned     RING_DEPTH     = 3;
   localparam int unsigned     PIPE_SLACK     = 6;
   localparam int unsigned     CYCLE_LIMIT    = 400000;
   localparam int unsigned     REPORT_LIMIT   = 10;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic                     req_echo_level   = 1'b0;
   logic [31:0]              req_timestamp_us = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [DIST_W-1:0] rsp_distance_cm;
   logic                     csr_wr_en        = 1'b0;
   logic [CFG_W-1:0]         csr_wr_data      = '0;

   // predicted block state
   logic [31:0]      pulse_start_us;
   logic [31:0]      width_ring [RING_DEPTH];
   int unsigned      ring_slot;
   logic [CFG_W-1:0] range_limit_cm;

   logic [DIST_W-1:0] expected_distance_q[$];
   logic [DIST_W-1:0] wanted_distance;
   logic [31:0]       now_us;
   bit                quiet;
   int unsigned       hold_cycles;
   int unsigned       cycle_count;
   int unsigned       error_count;
   int unsigned       request_count;
   int unsigned       response_count;
   int unsigned       range_write_count;
   int unsigned       out_of_range_count;

   sonar_echo_median_ranger dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_echo_level   (req_echo_level),
      .req_timestamp_us (req_timestamp_us),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_distance_cm  (rsp_distance_cm),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned draw_wait();
      if (quiet)
         return 0;
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
   endfunction

   // Advance the echo state by one edge and return the distance it reports.
   function automatic logic [DIST_W-1:0] predict_distance(input logic level,
                                                           input logic [31:0] stamp);
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mid;
      logic [31:0] cm;
      if (level == LEVEL_RISE) begin
         pulse_start_us = stamp;
      end else if (stamp > pulse_start_us) begin
         width_ring[ring_slot] = stamp - pulse_start_us;
         ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
      end
      lo  = (width_ring[0] < width_ring[1]) ? width_ring[0] : width_ring[1];
      hi  = (width_ring[0] < width_ring[1]) ? width_ring[1] : width_ring[0];
      mid = (hi < width_ring[2]) ? hi : width_ring[2];
      mid = (lo > mid) ? lo : mid;
      cm  = mid / US_PER_CM_CHK;
      if (cm > {22'd0, range_limit_cm})
         return DIST_INVALID;
      return cm[DIST_W-1:0];
   endfunction

   // Pick a pulse width: mostly random, sometimes near the current range limit.
   function automatic logic [31:0] draw_width();
      logic [31:0] edge_cm;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(1, 1100 * US_PER_CM_CHK);
         5:             return $urandom_range(0, US_PER_CM_CHK - 1);
         6:             return $urandom;
         7:             return 32'd0;
         default: begin
            edge_cm = {22'd0, range_limit_cm} + $urandom_range(0, 1);
            return edge_cm * US_PER_CM_CHK - $urandom_range(0, 1);
         end
      endcase
   endfunction

   task automatic send_edge(input logic level, input logic [31:0] stamp);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_echo_level   <= level;
      req_timestamp_us <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_distance_q.push_back(predict_distance(level, stamp));
      request_count++;
   endtask

   task automatic send_pulse(input logic [31:0] start, input logic [31:0] width);
      send_edge(LEVEL_RISE, start);
      send_edge(LEVEL_FALL, start + width);
   endtask

   task automatic idle_requests();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_distance_q.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   task automatic write_range_limit(input logic [CFG_W-1:0] limit);
      idle_requests();
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      range_limit_cm = limit;
      range_write_count++;
   endtask

   // Stray falls, wrapped and equal stamps, repeated rises, full-scale width.
   task automatic test_edge_cases();
      send_edge(LEVEL_FALL, 32'd0);
      send_edge(LEVEL_FALL, 32'd58 * 32'd600);
      send_edge(LEVEL_RISE, 32'd100);
      send_edge(LEVEL_RISE, 32'd200);
      send_edge(LEVEL_FALL, 32'd200 + 32'd58 * 32'd601);
      send_edge(LEVEL_RISE, 32'hFFFF_FF00);
      send_edge(LEVEL_FALL, 32'h0000_0010);
      send_edge(LEVEL_FALL, 32'hFFFF_FF00);
      send_pulse(32'h0000_0000, 32'hFFFF_FFFF);
      send_pulse(32'd1000, 32'd57);
      send_pulse(32'h8000_0000, 32'd1023 * 32'd58 + 32'd57);
   endtask

   // Limit at zero and at full scale, right at the distance boundaries.
   task automatic test_range_extremes();
      write_range_limit(RANGE_NONE);
      send_pulse(32'h0001_0000, 32'd57);
      send_pulse(32'h0002_0000, 32'd58);
      write_range_limit(RANGE_FULL);
      send_pulse(32'h5555_5555, 32'd1023 * 32'd58 + 32'd57);
      send_pulse(32'hAAAA_AAAA, 32'd1023 * 32'd58 + 32'd57);
      send_pulse(32'h7FFF_FFF0, 32'd1024 * 32'd58);
   endtask

   task automatic send_echo_traffic(input int unsigned count);
      int unsigned sent;
      int unsigned pick;
      logic [31:0] width;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            width = draw_width();
            send_pulse(now_us, width);
            now_us += width + $urandom_range(1, 4000);
            sent += 2;
         end else if (pick == 15) begin
            // repeated rise before the fall
            send_edge(LEVEL_RISE, now_us);
            now_us += $urandom_range(1, 20000);
            width = draw_width();
            send_pulse(now_us, width);
            now_us += width + 1;
            sent += 3;
         end else if (pick == 16) begin
            // fall with no rise in front of it
            now_us += draw_width();
            send_edge(LEVEL_FALL, now_us);
            sent += 1;
         end else if (pick == 17) begin
            send_edge(1'($urandom_range(0, 1)), $urandom);
            sent += 1;
         end else begin
            // jump the free-running clock, sometimes close to its wrap
            now_us = (pick == 18) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 80000);
         end
      end
   endtask

   task automatic test_random_phases();
      int unsigned phase;
      logic [CFG_W-1:0] limit;
      now_us = $urandom;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            1:       limit = RANGE_FULL;
            3:       limit = 10'h2AA;
            4:       limit = 10'h155;
            default: limit = CFG_W'($urandom_range(0, 1023));
         endcase
         write_range_limit(limit);
         quiet = (phase == 2);
         send_echo_traffic(120);
         if (phase == 3) begin
            // hold off until every response is back
            idle_requests();
            wait_drained();
         end
         send_echo_traffic(120);
         quiet = 1'b0;
      end
      write_range_limit(RANGE_AT_RESET);
      send_echo_traffic(40);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_distance_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         response_count++;
         if (expected_distance_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected response distance %0d", rsp_distance_cm);
         end else begin
            wanted_distance = expected_distance_q.pop_front();
            if (wanted_distance == DIST_INVALID)
               out_of_range_count++;
            if (rsp_distance_cm !== wanted_distance) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("distance mismatch on response %0d: expected %0d, got %0d",
                           response_count, $signed(wanted_distance), rsp_distance_cm);
            end
         end
         hold_cycles = draw_wait();
      end
      if (hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      pulse_start_us     = '0;
      width_ring         = '{default: '0};
      ring_slot          = 0;
      range_limit_cm     = RANGE_AT_RESET;
      quiet              = 1'b0;
      hold_cycles        = 0;
      cycle_count        = 0;
      error_count        = 0;
      request_count      = 0;
      response_count     = 0;
      range_write_count  = 0;
      out_of_range_count = 0;
      now_us             = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_cases();
      test_range_extremes();
      test_random_phases();

      idle_requests();
      wait_drained();
      $display("Sent %0d echo edges, checked %0d distances (%0d out of range)",
               request_count, response_count, out_of_range_count);
      $display("Range limit written %0d times, %0d errors", range_write_count, error_count);
      if (error_count == 0 && expected_distance_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/semr_pkg.sv
rtl/semr_front.sv
rtl/semr_queue.sv
rtl/semr_back.sv
rtl/sonar_echo_median_ranger.sv
verif/tb_sonar_echo_median_ranger.sv
